// File: rtl/core/lpsm_pkg.sv
// shared types and constants for the layer priority and shadow mixer
package lpsm_pkg;

  localparam int unsigned IndexW = 6;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  // sprite codes with special meaning under shadow and highlight
  localparam logic [IndexW-1:0] SprNormal0   = 6'h0e;
  localparam logic [IndexW-1:0] SprNormal1   = 6'h1e;
  localparam logic [IndexW-1:0] SprNormal2   = 6'h2e;
  localparam logic [IndexW-1:0] SprHighlight = 6'h3e;
  localparam logic [IndexW-1:0] SprShadow    = 6'h3f;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BACKDROP   = 2'd0,
    CFG_SHADOW_HL  = 2'd1,
    CFG_LAYERS_OFF = 2'd2,
    CFG_FORCE_SEL  = 2'd3
  } cfg_idx_e;

  // forced layer select codes
  typedef enum logic [1:0] {
    FORCE_NONE    = 2'd0,
    FORCE_SPRITE  = 2'd1,
    FORCE_PLANE_A = 2'd2,
    FORCE_PLANE_B = 2'd3
  } force_sel_e;

  // intensity codes
  typedef enum logic [ModeW-1:0] {
    MODE_SHADOW    = 2'd0,
    MODE_NORMAL    = 2'd1,
    MODE_HIGHLIGHT = 2'd2
  } mode_e;

  // one input dot
  typedef struct packed {
    logic              draw_enable;
    logic [IndexW-1:0] a_index;
    logic              a_prio;
    logic [IndexW-1:0] b_index;
    logic              b_prio;
    logic [IndexW-1:0] s_index;
    logic              s_prio;
  } dot_in_t;

  // one result dot
  typedef struct packed {
    logic [IndexW-1:0] out_index;
    logic [ModeW-1:0]  mode;
    logic              is_backdrop;
  } dot_out_t;

endpackage

// File: rtl/core/layer_priority_shadow_mixer.sv
// Pipeline: input register, then result register; a stalled result stage holds items back in the input register.
// Throughput: one dot per cycle while m_axis_tready is high.
// Each stage takes a new item whenever it is empty or its item leaves in the same cycle.
// Reset: asynchronous active low; clears both stage valids and all config registers.
// The user must write configuration only while no item is in flight; the block does not enforce this.
module layer_priority_shadow_mixer
  import lpsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input dot stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: plane_a_index, plane_a_prio, plane_b_index, plane_b_prio,
  //        sprite_index, sprite_prio, 3 zero bits
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: draw_enable
  input  logic                s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: out_index, intensity_mode
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: is_backdrop
  output logic                m_axis_tuser
);

  // configuration registers
  logic [IndexW-1:0] backdrop_q;
  logic              sh_on_q;
  logic              layers_off_q;
  force_sel_e        force_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backdrop_q   <= '0;
      sh_on_q      <= 1'b0;
      layers_off_q <= 1'b0;
      force_sel_q  <= FORCE_NONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BACKDROP:   backdrop_q   <= cfg_wdata_i;
        CFG_SHADOW_HL:  sh_on_q      <= cfg_wdata_i[0];
        CFG_LAYERS_OFF: layers_off_q <= cfg_wdata_i[0];
        CFG_FORCE_SEL:  force_sel_q  <= force_sel_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // stage handshakes
  logic     in_v_q, out_v_q;
  logic     in_ready, out_ready;
  dot_in_t  in_q;
  dot_out_t out_q, out_d;

  assign out_ready     = !out_v_q || m_axis_tready;
  assign in_ready      = !in_v_q || out_ready;
  assign s_axis_tready = in_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      in_q.draw_enable <= s_axis_tuser;
      in_q.a_index     <= s_axis_tdata[5:0];
      in_q.a_prio      <= s_axis_tdata[6];
      in_q.b_index     <= s_axis_tdata[12:7];
      in_q.b_prio      <= s_axis_tdata[13];
      in_q.s_index     <= s_axis_tdata[19:14];
      in_q.s_prio      <= s_axis_tdata[20];
    end
  end

  // priority, shadow/highlight and test force logic
  always_comb begin
    logic [IndexW-1:0] a_idx, b_idx, s_idx, g_idx, bg_idx, pix_idx, f_idx;
    logic              a_pr, b_pr, s_pr, g_bd, bg_bd, pix_bd;
    logic              a_sol, b_sol, s_sol, a_abv, b_abv, s_abv, fg_s;
    logic [ModeW-1:0]  mode;

    a_idx = in_q.a_index;
    a_pr  = in_q.a_prio;
    b_idx = in_q.b_index;
    b_pr  = in_q.b_prio;
    s_idx = in_q.s_index;
    s_pr  = in_q.s_prio;
    g_idx = backdrop_q;
    g_bd  = 1'b1;

    // test disable: all layers are cleared and a forced layer takes the backdrop's place
    if (layers_off_q) begin
      unique case (force_sel_q)
        FORCE_SPRITE:  begin g_idx = s_idx; g_bd = 1'b0; end
        FORCE_PLANE_A: begin g_idx = a_idx; g_bd = 1'b0; end
        FORCE_PLANE_B: begin g_idx = b_idx; g_bd = 1'b0; end
        default: ;
      endcase
      a_idx = '0;
      b_idx = '0;
      s_idx = '0;
      a_pr  = 1'b0;
      b_pr  = 1'b0;
      s_pr  = 1'b0;
    end

    a_sol = |a_idx[3:0];
    b_sol = |b_idx[3:0];
    s_sol = |s_idx[3:0];
    a_abv = a_sol && a_pr;
    b_abv = b_sol && b_pr;
    s_abv = s_sol && s_pr;

    // background layer choice
    if (a_abv || (a_sol && !b_abv)) begin
      bg_idx = a_idx;
      bg_bd  = 1'b0;
    end else if (b_sol) begin
      bg_idx = b_idx;
      bg_bd  = 1'b0;
    end else begin
      bg_idx = g_idx;
      bg_bd  = g_bd;
    end

    fg_s    = s_abv || (s_sol && !b_abv && !a_abv);
    pix_idx = fg_s ? s_idx : bg_idx;
    pix_bd  = fg_s ? 1'b0 : bg_bd;
    mode    = MODE_NORMAL;

    // shadow and highlight
    if (sh_on_q) begin
      mode = {1'b0, a_pr | b_pr};
      if (fg_s) begin
        unique case (s_idx)
          SprNormal0, SprNormal1, SprNormal2: mode = MODE_NORMAL;
          SprHighlight: begin
            mode    = mode + 2'd1;
            pix_idx = bg_idx;
            pix_bd  = bg_bd;
          end
          SprShadow: begin
            mode    = MODE_SHADOW;
            pix_idx = bg_idx;
            pix_bd  = bg_bd;
          end
          default: mode = mode | {1'b0, s_pr};
        endcase
      end
    end

    // force without disable: replace backdrop, then mask with forced index
    unique case (force_sel_q)
      FORCE_SPRITE:  f_idx = in_q.s_index;
      FORCE_PLANE_A: f_idx = in_q.a_index;
      default:       f_idx = in_q.b_index;
    endcase
    if (!layers_off_q && force_sel_q != FORCE_NONE) begin
      if (pix_bd) begin
        pix_idx = f_idx;
        pix_bd  = 1'b0;
      end
      pix_idx = pix_idx & f_idx;
    end

    // blanked dot shows the backdrop
    if (!in_q.draw_enable) begin
      out_d.out_index   = backdrop_q;
      out_d.mode        = MODE_NORMAL;
      out_d.is_backdrop = 1'b1;
    end else begin
      out_d.out_index   = pix_idx;
      out_d.mode        = mode;
      out_d.is_backdrop = pix_bd;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_v_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.mode, out_q.out_index};
  assign m_axis_tuser  = out_q.is_backdrop;

`ifndef SYNTHESIS
  // intensity code never takes the unused value
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q.mode != 2'd3)
    else $error("intensity mode out of range");

  // without shadow/highlight every result is normal intensity
  a_mode_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !sh_on_q) |-> out_q.mode == MODE_NORMAL)
    else $error("intensity changed with shadow/highlight off");

  // a backdrop result always carries the backdrop index
  a_backdrop_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.is_backdrop) |-> out_q.out_index == backdrop_q)
    else $error("backdrop flag with foreign index");

  // an item in the input register moves on when the result stage frees up
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && out_ready) |=> out_v_q)
    else $error("item lost between stages");
`endif

endmodule
